@@ design/shar_pkg.sv @@
`timescale 1ns / 1ps

package shar_pkg;

  // default ring depth
  localparam int DEPTH_DEFAULT = 128;

  // sample and margin widths (signed Q8.8, unsigned Q7.8)
  localparam int SAMPLE_W = 16;
  localparam int MARGIN_W = 15;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  // operation codes
  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOCK_LOW   = 3'd0,
    REG_LOCK_HIGH  = 3'd1,
    REG_FIXED_LOW  = 3'd2,
    REG_FIXED_HIGH = 3'd3,
    REG_MARGIN     = 3'd4
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WIDEN
  } state_t;

  // input request
  typedef struct packed {
    logic               op;
    logic signed [15:0] sample;
  } req_t;

  // result
  typedef struct packed {
    logic signed [15:0] range_low;
    logic signed [15:0] range_high;
  } res_t;

  // ring memory write port
  typedef struct packed {
    logic               we;
    logic signed [15:0] wdata;
  } ram_wr_t;

endpackage

@@ design/shar_ram.sv @@
`timescale 1ns / 1ps

module shar_ram
  import shar_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  ram_wr_t                    wr,
  input  logic [AW-1:0]              waddr,
  input  logic [AW-1:0]              raddr,
  output logic signed [SAMPLE_W-1:0] rdata
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/sample_history_autorange.sv @@
`timescale 1ns / 1ps

// sample history ring with min/max display range query
//
// request channel: a request is taken at a rising edge with start high and
// busy low. op push writes the sample into the ring at that edge and busy
// stays low, so pushes can follow every cycle while no query runs. op query
// raises busy while the ring is scanned oldest to newest through the single
// registered read port of the ring memory, one entry per cycle through one
// shared min/max compare unit; every stored sample is read (one slot on an
// empty ring). busy stays high through scan, last and widen, then strobe
// is high for exactly one cycle with the result on result. The receiver
// cannot stall; strobe drops after that cycle, result stays until replaced.
// config channel: cfg_ready is always high; write only while idle.
// reset: synchronous, clears the ring pointers and loads register defaults
// (both sides bound, fixed values zero, margin 26). The ring memory itself
// is not swept: an empty ring that never saw a push reads as zero.
module sample_history_autorange
  import shar_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  req_t                   request,
  output logic                   strobe,
  output res_t                   result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_INDEX = AW'(DEPTH - 1);

  state_t state, state_next;

  logic [AW-1:0] head, oldest, addr, remain;
  logic          filled;
  logic          rd_valid, first;
  logic          issue;

  logic signed [SAMPLE_W-1:0] rdata, scan_data, lo, hi;

  logic                       lock_low, lock_high;
  logic signed [SAMPLE_W-1:0] fixed_low, fixed_high;
  logic [MARGIN_W-1:0]        margin;

  ram_wr_t ram_wr;
  logic    push_acc, query_acc;

  function automatic logic [AW-1:0] next_index(input logic [AW-1:0] i);
    return (i == LAST_INDEX) ? '0 : i + AW'(1);
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign push_acc  = start && !busy && (request.op == OP_PUSH);
  assign query_acc = start && !busy && (request.op == OP_QUERY);

  // ring memory
  assign ram_wr.we    = push_acc;
  assign ram_wr.wdata = request.sample;

  shar_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .waddr (head),
    .raddr (addr),
    .rdata (rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_low   <= 1'b1;
      lock_high  <= 1'b1;
      fixed_low  <= '0;
      fixed_high <= '0;
      margin     <= MARGIN_W'(26);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOCK_LOW:   lock_low   <= cfg_data[0];
        REG_LOCK_HIGH:  lock_high  <= cfg_data[0];
        REG_FIXED_LOW:  fixed_low  <= cfg_data;
        REG_FIXED_HIGH: fixed_high <= cfg_data;
        REG_MARGIN:     margin     <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      oldest <= '0;
      filled <= 1'b0;
    end else if (push_acc) begin
      head   <= next_index(head);
      filled <= 1'b1;
      if (next_index(head) == oldest) begin
        oldest <= next_index(oldest);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (query_acc) state_next = ST_SCAN;
      ST_SCAN:  if (remain == AW'(1)) state_next = ST_LAST;
      ST_LAST:  state_next = ST_WIDEN;
      ST_WIDEN: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    issue = 1'b0;
    case (state)
      ST_SCAN: issue = 1'b1;
      default: issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      strobe   <= (state == ST_WIDEN);
    end
  end

  // scan address and count
  always_ff @(posedge clk) begin
    if (query_acc) begin
      addr   <= oldest;
      remain <= (head == oldest) ? AW'(1) :
                (head > oldest)  ? head - oldest :
                                   AW'(DEPTH + int'(head) - int'(oldest));
    end else if (issue) begin
      addr   <= next_index(addr);
      remain <= remain - AW'(1);
    end
  end

  // slot never written reads as zero
  assign scan_data = filled ? rdata : '0;

  // shared min/max compare unit
  always_ff @(posedge clk) begin
    if (query_acc) begin
      first <= 1'b1;
    end else if (rd_valid) begin
      first <= 1'b0;
      if (first || scan_data < lo) lo <= scan_data;
      if (first || scan_data > hi) hi <= scan_data;
    end
  end

  // widening with saturation when min equals max, then bound sides
  logic signed [SAMPLE_W:0] lo_wide, hi_wide;
  logic signed [SAMPLE_W-1:0] lo_sat, hi_sat, lo_out, hi_out;

  always_comb begin
    lo_wide = {lo[SAMPLE_W-1], lo} - $signed({2'b00, margin});
    hi_wide = {hi[SAMPLE_W-1], hi} + $signed({2'b00, margin});
    lo_sat  = (lo_wide[SAMPLE_W] != lo_wide[SAMPLE_W-1]) ?
              {1'b1, {(SAMPLE_W-1){1'b0}}} : lo_wide[SAMPLE_W-1:0];
    hi_sat  = (hi_wide[SAMPLE_W] != hi_wide[SAMPLE_W-1]) ?
              {1'b0, {(SAMPLE_W-1){1'b1}}} : hi_wide[SAMPLE_W-1:0];
    lo_out  = (lo == hi) ? lo_sat : lo;
    hi_out  = (lo == hi) ? hi_sat : hi;
    if (lock_low)  lo_out = fixed_low;
    if (lock_high) hi_out = fixed_high;
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_WIDEN) begin
      result.range_low  <= lo_out;
      result.range_high <= hi_out;
    end
  end

endmodule

@@ design/shar_checker.sv @@
`timescale 1ns / 1ps

module shar_checker
  import shar_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t request,
  input logic strobe
);

  // a result never shows while a query is still running
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("strobe while busy");

  // one result per query, never two in a row
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("strobe held for two cycles");

  // an accepted query starts a scan
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.op == OP_QUERY) |=> busy)
    else $error("query did not raise busy");

  // a push finishes at once and gives no result
  a_push_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.op == OP_PUSH) |=> (!busy && !strobe))
    else $error("push raised busy or strobe");

endmodule

bind sample_history_autorange shar_checker u_shar_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .strobe  (strobe)
);
